@@ src/vctk_pkg.sv @@
`timescale 1ns / 1ps

package vctk_pkg;

   localparam int ID_W   = 13;
   localparam int VOTE_W = 16;
   localparam int TOPK_W = 7;

   localparam logic [VOTE_W-1:0] VOTE_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WAIT,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } vctk_state_type;

   typedef enum logic {
      CSR_NUM_POINTS = 1'b0,
      CSR_TOP_K      = 1'b1
   } vctk_csr_type;

   typedef struct packed {
      logic vote_en;
      logic sweep_en;
   } vctk_mem_ctl_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } vctk_row_ctl_type;

endpackage

@@ src/vote_count_top_k_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                            Handshake
// request   req_point_id, req_point_valid, req_last_item     start & !busy
// response  rsp_ranked_point, rsp_vote_total, rsp_last_result  rsp_valid, one cycle each
// csr       csr_index, csr_data                              csr_write
//
// Votes: one per cycle while busy is low, counter read-modify-write with a forwarding stage.
// A last transaction keeps busy high through a wait state (vote write), the scan
// with clear, a drain state and one emit state per result; min(top_k, MAX_TOP,
// num_points) results follow one per cycle, each in the cycle after its emit cycle.
// After reset the counter memory is cleared in a pass over all POINTS counters with busy high.
// Results cannot be stalled.

module vote_count_top_k_unit #(
   parameter int POINTS  = 4096,
   parameter int MAX_TOP = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [vctk_pkg::ID_W-1:0]    req_point_id,
   input  logic                         req_point_valid,
   input  logic                         req_last_item,
   output logic                         rsp_valid,
   output logic [vctk_pkg::ID_W-1:0]    rsp_ranked_point,
   output logic [vctk_pkg::VOTE_W-1:0]  rsp_vote_total,
   output logic                         rsp_last_result,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [vctk_pkg::ID_W-1:0]    csr_data
);
   import vctk_pkg::*;

   localparam int AW    = $clog2(POINTS);
   localparam int CAP_I = (POINTS > 8191) ? 8191 : POINTS;
   localparam logic [ID_W-1:0]   CAP       = ID_W'(CAP_I);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(POINTS - 1);
   localparam logic [TOPK_W-1:0] TOP_CAP   = TOPK_W'(MAX_TOP);

   vctk_state_type    state_ff, state_in;
   logic [ID_W-1:0]   num_points_ff;
   logic [TOPK_W-1:0] top_k_ff;
   logic [AW-1:0]     scan_ff, scan_in;
   logic              sc_vld_ff;
   logic [AW-1:0]     sc_idx_ff;
   logic [TOPK_W-1:0] rank_ff, rank_in;
   logic [TOPK_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [ID_W-1:0]   rsp_point_ff;
   logic [VOTE_W-1:0] rsp_votes_ff;

   logic [ID_W-1:0]   eff_n;
   logic              accept;
   logic              vote_hit;
   logic [ID_W-1:0]   id_m1;
   logic [TOPK_W-1:0] k_top;
   logic [TOPK_W-1:0] k_eff;
   logic              in_range;

   vctk_mem_ctl_type  mem_ctl;
   vctk_row_ctl_type  row_ctl;
   logic [VOTE_W-1:0] rd_votes;
   logic [VOTE_W-1:0] head_votes;
   logic [AW-1:0]     head_point;

   always_comb begin
      busy     = (state_ff != ST_IDLE);
      accept   = start && !busy;
      eff_n    = (num_points_ff > CAP) ? CAP : num_points_ff;
      vote_hit = req_point_valid && (req_point_id != '0) && (req_point_id <= eff_n);
      id_m1    = req_point_id - 1'b1;
      k_top    = (top_k_ff > TOP_CAP) ? TOP_CAP : top_k_ff;
      k_eff    = (ID_W'(k_top) > eff_n) ? eff_n[TOPK_W-1:0] : k_top;
      in_range = (17'(sc_idx_ff) < 17'(eff_n));
      mem_ctl.vote_en  = accept && vote_hit;
      mem_ctl.sweep_en = (state_ff == ST_CLEAR) || (state_ff == ST_SCAN);
   end

   vctk_vote_mem #(
      .DEPTH (POINTS)
   ) u_vote_mem (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mem_ctl),
      .vote_addr  (AW'(id_m1)),
      .sweep_addr (scan_ff),
      .rd_votes   (rd_votes)
   );

   vctk_rank_row #(
      .DEPTH (MAX_TOP),
      .IDX_W (AW)
   ) u_rank_row (
      .clock      (clock),
      .reset      (reset),
      .ctl        (row_ctl),
      .in_votes   (rd_votes),
      .in_point   (sc_idx_ff),
      .head_votes (head_votes),
      .head_point (head_point)
   );

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      rank_in        = rank_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_last_in    = 1'b0;
      row_ctl.clear  = 1'b0;
      row_ctl.shift  = 1'b0;
      row_ctl.insert = sc_vld_ff && in_range;
      unique case (state_ff)
         ST_CLEAR: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_ADDR) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_last_item) begin
               cnt_in   = k_eff;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            row_ctl.clear = 1'b1;
            scan_in       = '0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_ADDR) begin
               scan_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rank_in  = '0;
            state_in = (cnt_ff == '0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            row_ctl.shift = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_last_in   = (rank_ff == cnt_ff - 1'b1);
            rank_in       = rank_ff + 1'b1;
            if (rsp_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         sc_vld_ff    <= 1'b0;
         rank_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         sc_vld_ff    <= (state_ff == ST_SCAN);
         rank_ff      <= rank_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= 13'd4096;
         top_k_ff      <= 7'd1;
      end else if (csr_write) begin
         if (csr_index == CSR_NUM_POINTS) begin
            num_points_ff <= csr_data;
         end else if (csr_index == CSR_TOP_K) begin
            top_k_ff <= csr_data[TOPK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      sc_idx_ff    <= scan_ff;
      rsp_last_ff  <= rsp_last_in;
      rsp_point_ff <= ID_W'(head_point) + 1'b1;
      rsp_votes_ff <= head_votes;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_last_result  = rsp_valid_ff && rsp_last_ff;
   assign rsp_ranked_point = rsp_point_ff;
   assign rsp_vote_total   = rsp_votes_ff;

endmodule

@@ src/vctk_vote_mem.sv @@
`timescale 1ns / 1ps

module vctk_vote_mem #(
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vctk_pkg::vctk_mem_ctl_type    ctl,
   input  logic [ADDR_W-1:0]             vote_addr,
   input  logic [ADDR_W-1:0]             sweep_addr,
   output logic [vctk_pkg::VOTE_W-1:0]   rd_votes
);
   import vctk_pkg::*;

   logic [VOTE_W-1:0] mem [DEPTH];
   logic [VOTE_W-1:0] rd_ff;

   logic              s1_vld_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s2_vld_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [VOTE_W-1:0] s2_val_ff;

   logic [VOTE_W-1:0] cur_votes;
   logic [VOTE_W-1:0] bumped;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VOTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   // forward the write of the previous transaction when it hits the same counter
   always_comb begin
      cur_votes = (s2_vld_ff && (s2_addr_ff == s1_addr_ff)) ? s2_val_ff : rd_ff;
      bumped    = (cur_votes == VOTE_MAX) ? cur_votes : cur_votes + 1'b1;
      wr_en     = s1_vld_ff || ctl.sweep_en;
      wr_addr   = s1_vld_ff ? s1_addr_ff : sweep_addr;
      wr_data   = s1_vld_ff ? bumped : '0;
      rd_en     = ctl.vote_en || ctl.sweep_en;
      rd_addr   = ctl.sweep_en ? sweep_addr : vote_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ctl.vote_en;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= vote_addr;
      s2_addr_ff <= s1_addr_ff;
      s2_val_ff  <= bumped;
   end

   assign rd_votes = rd_ff;

endmodule

@@ src/vctk_rank_row.sv @@
`timescale 1ns / 1ps

module vctk_rank_row #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vctk_pkg::vctk_row_ctl_type    ctl,
   input  logic [vctk_pkg::VOTE_W-1:0]   in_votes,
   input  logic [IDX_W-1:0]              in_point,
   output logic [vctk_pkg::VOTE_W-1:0]   head_votes,
   output logic [IDX_W-1:0]              head_point
);
   import vctk_pkg::*;

   logic [VOTE_W-1:0] votes_ff [DEPTH];
   logic [IDX_W-1:0]  point_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;

   logic [VOTE_W-1:0] votes_in [DEPTH];
   logic [IDX_W-1:0]  point_in [DEPTH];
   logic [DEPTH-1:0]  vld_in;

   logic [DEPTH-1:0]  gt;
   logic [DEPTH-1:0]  gt_prv;
   logic [VOTE_W-1:0] prv_votes [DEPTH];
   logic [IDX_W-1:0]  prv_point [DEPTH];
   logic [DEPTH-1:0]  prv_vld;
   logic [VOTE_W-1:0] nxt_votes [DEPTH];
   logic [IDX_W-1:0]  nxt_point [DEPTH];
   logic [DEPTH-1:0]  nxt_vld;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      assign gt[j] = !vld_ff[j] || (in_votes > votes_ff[j]);
      if (j == 0) begin : g_first
         assign gt_prv[j]    = 1'b0;
         assign prv_votes[j] = '0;
         assign prv_point[j] = '0;
         assign prv_vld[j]   = 1'b0;
      end else begin : g_mid
         assign gt_prv[j]    = gt[j-1];
         assign prv_votes[j] = votes_ff[j-1];
         assign prv_point[j] = point_ff[j-1];
         assign prv_vld[j]   = vld_ff[j-1];
      end
      if (j == DEPTH - 1) begin : g_last
         assign nxt_votes[j] = '0;
         assign nxt_point[j] = '0;
         assign nxt_vld[j]   = 1'b0;
      end else begin : g_body
         assign nxt_votes[j] = votes_ff[j+1];
         assign nxt_point[j] = point_ff[j+1];
         assign nxt_vld[j]   = vld_ff[j+1];
      end
   end

   // strict compare keeps the lower point ahead on equal votes
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         votes_in[j] = votes_ff[j];
         point_in[j] = point_ff[j];
         vld_in[j]   = vld_ff[j];
         if (ctl.clear) begin
            vld_in[j] = 1'b0;
         end else if (ctl.shift) begin
            votes_in[j] = nxt_votes[j];
            point_in[j] = nxt_point[j];
            vld_in[j]   = nxt_vld[j];
         end else if (ctl.insert) begin
            if (gt_prv[j]) begin
               votes_in[j] = prv_votes[j];
               point_in[j] = prv_point[j];
               vld_in[j]   = prv_vld[j];
            end else if (gt[j]) begin
               votes_in[j] = in_votes;
               point_in[j] = in_point;
               vld_in[j]   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         votes_ff[j] <= votes_in[j];
         point_ff[j] <= point_in[j];
      end
   end

   assign head_votes = votes_ff[0];
   assign head_point = point_ff[0];

endmodule

@@ src/vctk_checker.sv @@
`timescale 1ns / 1ps

module vctk_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_last_item,
   input logic                         rsp_valid,
   input logic                         rsp_last_result,
   input logic [vctk_pkg::VOTE_W-1:0]  rsp_vote_total
);

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |-> rsp_valid)
      else $error("last result flagged without a result");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid)
      else $error("result burst broken before its last transaction");

   a_busy_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("request taken while results remain");

   a_last_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_item |=> busy)
      else $error("round end did not raise busy");

   a_votes_descend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_vote_total <= $past(rsp_vote_total))
      else $error("ranked votes not in descending order");

endmodule

bind vote_count_top_k_unit vctk_checker u_vctk_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import vctk_pkg::*;

   localparam int POINTS         = 4096;
   localparam int MAX_TOP        = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic            valid;
      logic            last;
   } ballot_type;

   typedef struct packed {
      logic [ID_W-1:0]   point;
      logic [VOTE_W-1:0] votes;
      logic              last;
   } ranked_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic [ID_W-1:0]     req_point_id    = '0;
   logic                req_point_valid = 1'b0;
   logic                req_last_item   = 1'b0;
   logic                rsp_valid;
   logic [ID_W-1:0]     rsp_ranked_point;
   logic [VOTE_W-1:0]   rsp_vote_total;
   logic                rsp_last_result;
   logic                csr_write       = 1'b0;
   logic                csr_index       = 1'b0;
   logic [ID_W-1:0]     csr_data        = '0;

   ballot_type          ballot_q[$];
   ranked_type          ranking_q[$];
   logic [VOTE_W-1:0]   tally [POINTS];
   bit                  rank_taken [POINTS];
   logic [ID_W-1:0]     pts_cfg;
   logic [TOPK_W-1:0]   topk_cfg;
   int                  send_gap_pct = 9;
   int                  fail_count   = 0;
   int                  quiet_cycles = 0;

   vote_count_top_k_unit #(
      .POINTS  (POINTS),
      .MAX_TOP (MAX_TOP)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_point_id     (req_point_id),
      .req_point_valid  (req_point_valid),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ranked_point (rsp_ranked_point),
      .rsp_vote_total   (rsp_vote_total),
      .rsp_last_result  (rsp_last_result),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic tally_and_rank(input logic [ID_W-1:0] id, input logic valid,
                                 input logic last);
      int         n;
      int         k;
      int         best;
      ranked_type entry;
      n = (pts_cfg > POINTS) ? POINTS : pts_cfg;
      if (valid && id >= 1 && id <= n && tally[id - 1] != VOTE_MAX) begin
         tally[id - 1] = tally[id - 1] + 1'b1;
      end
      if (last) begin
         k = (topk_cfg > MAX_TOP) ? MAX_TOP : topk_cfg;
         if (k > n) begin
            k = n;
         end
         for (int i = 0; i < POINTS; i++) begin
            rank_taken[i] = 1'b0;
         end
         for (int r = 0; r < k; r++) begin
            best = -1;
            for (int i = 0; i < n; i++) begin
               if (!rank_taken[i] && (best < 0 || tally[i] > tally[best])) begin
                  best = i;
               end
            end
            rank_taken[best] = 1'b1;
            entry.point = ID_W'(best + 1);
            entry.votes = tally[best];
            entry.last  = (r == k - 1);
            ranking_q.push_back(entry);
         end
         for (int i = 0; i < POINTS; i++) begin
            tally[i] = '0;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            ballot_q.delete(0);
         end
         if (start && busy) begin
            // hold the pending transaction
         end else if (ballot_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            start           <= 1'b1;
            req_point_id    <= ballot_q[0].id;
            req_point_valid <= ballot_q[0].valid;
            req_last_item   <= ballot_q[0].last;
         end else begin
            start           <= 1'b0;
            req_point_id    <= ID_W'($urandom);
            req_point_valid <= 1'($urandom);
            req_last_item   <= 1'($urandom);
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      ranked_type want;
      if (reset) begin
         pts_cfg  = 13'd4096;
         topk_cfg = 7'd1;
         for (int i = 0; i < POINTS; i++) begin
            tally[i] = '0;
         end
         quiet_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (ranking_q.size() == 0) begin
               $display("%0t: expected no result, actual ranked_point %0d vote_total %0d",
                        $time, rsp_ranked_point, rsp_vote_total);
               fail_count++;
            end else begin
               want = ranking_q.pop_front();
               if (rsp_ranked_point !== want.point) begin
                  $display("%0t: ranked_point expected %0d actual %0d",
                           $time, want.point, rsp_ranked_point);
                  fail_count++;
               end
               if (rsp_vote_total !== want.votes) begin
                  $display("%0t: vote_total expected %0d actual %0d",
                           $time, want.votes, rsp_vote_total);
                  fail_count++;
               end
               if (rsp_last_result !== want.last) begin
                  $display("%0t: last_result expected %0d actual %0d",
                           $time, want.last, rsp_last_result);
                  fail_count++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_NUM_POINTS: pts_cfg = csr_data;
               CSR_TOP_K:      topk_cfg = csr_data[TOPK_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            tally_and_rank(req_point_id, req_point_valid, req_last_item);
         end
         if ((start && !busy) || rsp_valid || csr_write) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic push_ballot(input logic [ID_W-1:0] id, input logic valid,
                              input logic last);
      ballot_type b;
      b.id    = id;
      b.valid = valid;
      b.last  = last;
      ballot_q.push_back(b);
   endtask

   task automatic wait_quiet();
      while (ballot_q.size() != 0 || start || ranking_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (POINTS + 8) @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
   endtask

   task automatic program_csr(input logic [ID_W-1:0] pts, input logic [TOPK_W-1:0] k);
      logic [ID_W-TOPK_W-1:0] pad;
      pad = (ID_W-TOPK_W)'($urandom);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_NUM_POINTS;
      csr_data  <= pts;
      @(posedge clock);
      csr_index <= CSR_TOP_K;
      csr_data  <= {pad, k};
      @(posedge clock);
      csr_write <= 1'b0;
      csr_data  <= ID_W'($urandom);
      @(negedge clock);
   endtask

   task automatic queue_round(input int n, input int len);
      int              hot [4];
      int              span;
      int              pick;
      logic [ID_W-1:0] id;
      span = (n < 1) ? 1 : ((n > POINTS) ? POINTS : n);
      for (int h = 0; h < 4; h++) begin
         hot[h] = $urandom_range(span, 1);
      end
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            id = ID_W'(hot[$urandom_range(3)]);
         end else if (pick < 8) begin
            id = ID_W'($urandom_range(span, 1));
         end else begin
            id = ID_W'($urandom);
         end
         push_ballot(id, $urandom_range(9) != 0, i == len - 1);
      end
   endtask

   initial begin
      logic [ID_W-1:0]   pts;
      logic [TOPK_W-1:0] k;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      wait_quiet();

      // round on the reset settings
      push_ballot(13'd4096, 1'b1, 1'b0);
      push_ballot(13'd4096, 1'b1, 1'b0);
      push_ballot(13'd7, 1'b1, 1'b1);
      wait_quiet();

      program_csr(13'd8191, 7'd127);
      push_ballot(13'd0, 1'b1, 1'b0);
      push_ballot(13'd8191, 1'b1, 1'b0);
      push_ballot(13'd1, 1'b1, 1'b0);
      push_ballot(13'd2, 1'b0, 1'b0);
      push_ballot(13'd4096, 1'b0, 1'b1);
      wait_quiet();

      program_csr(13'd5, 7'd3);
      push_ballot(13'd3, 1'b1, 1'b0);
      push_ballot(13'd5, 1'b1, 1'b0);
      push_ballot(13'd3, 1'b1, 1'b0);
      push_ballot(13'd5, 1'b1, 1'b0);
      push_ballot(13'd2, 1'b1, 1'b0);
      push_ballot(13'd6, 1'b1, 1'b0);
      push_ballot(13'd1, 1'b1, 1'b1);
      wait_quiet();

      program_csr(13'd5, 7'd0);
      push_ballot(13'd1, 1'b1, 1'b0);
      push_ballot(13'd2, 1'b1, 1'b1);
      wait_quiet();

      program_csr(13'd0, 7'd4);
      push_ballot(13'd1, 1'b1, 1'b1);
      wait_quiet();

      program_csr(13'd10, 7'd10);
      push_ballot(13'd9, 1'b1, 1'b0);
      push_ballot(13'd10, 1'b1, 1'b0);
      push_ballot(13'd10, 1'b1, 1'b0);
      wait_quiet();
      program_csr(13'd8, 7'd10);
      push_ballot(13'd1, 1'b1, 1'b1);
      wait_quiet();

      program_csr(13'd1, 7'd1);
      push_ballot(13'd2, 1'b1, 1'b0);
      push_ballot(13'd1, 1'b1, 1'b1);
      wait_quiet();

      program_csr(13'd3, 7'd64);
      push_ballot(13'd2, 1'b1, 1'b0);
      push_ballot(13'd0, 1'b0, 1'b1);

      for (int ph = 0; ph < 3; ph++) begin
         for (int c = 0; c < 5; c++) begin
            wait_quiet();
            send_gap_pct = (ph == 0) ? 9 : ((ph == 1) ? 49 : 0);
            case ($urandom_range(5))
               0:       pts = 13'd1;
               1:       pts = 13'd4096;
               2:       pts = ID_W'($urandom_range(8191, 4097));
               3:       pts = ID_W'($urandom_range(4096, 1));
               default: pts = ID_W'($urandom_range(40, 2));
            endcase
            case ($urandom_range(4))
               0:       k = 7'd64;
               1:       k = TOPK_W'($urandom_range(127, 65));
               2:       k = 7'd1;
               default: k = TOPK_W'($urandom_range(20, 1));
            endcase
            program_csr(pts, k);
            queue_round(pts, $urandom_range(30, 1));
            queue_round(pts, $urandom_range(30, 1));
         end
      end
      wait_quiet();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
